@@ src/dmarb_pkg.sv @@
// Shared constants, codes and types of the DMA register block.
package dmarb_pkg;

  localparam int CHANNEL_COUNT = 3;
  localparam int MATRIX_WORDS = 17;
  localparam int FB_WORDS = 5;

  localparam int CHAN_W = 2;
  localparam int MAT_IDX_W = (MATRIX_WORDS > 1) ? $clog2(MATRIX_WORDS) : 1;
  localparam int FB_IDX_W = 3;
  localparam int IRQ_W = 5;
  localparam int BEATS_W = 12;
  localparam int DELAY_W = 15;

  localparam logic [31:0] ADDR_IRQ_STATUS = 32'h1C80_0004;
  localparam logic [31:0] ADDR_IRQ_CLEAR = 32'h1C80_0008;
  localparam logic [31:0] ADDR_ERR_STATUS = 32'h1C80_000C;
  localparam logic [31:0] ADDR_FB_BASE = 32'h1C80_0100;
  localparam logic [31:0] ADDR_FB_LAST = ADDR_FB_BASE + 32'h10;
  localparam logic [31:0] ADDR_CSC_BASE = 32'h1C80_0120;
  localparam logic [31:0] ADDR_CSC_END = ADDR_CSC_BASE + 32'(4 * MATRIX_WORDS);
  localparam logic [31:0] ADDR_CHN_BASE = 32'h1C80_0180;
  localparam logic [31:0] ADDR_CHN_END =
    ADDR_CHN_BASE + 32'(32 * (CHANNEL_COUNT - 1)) + 32'h14;
  localparam logic [31:0] CHN_LANE_MASK = ~32'h60;
  localparam logic [31:0] CHN_OFF_LAST = 32'h10;
  localparam logic [31:0] ATTR_KEEP = 32'h8FFF_FFFF;
  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(CHANNEL_COUNT - 1);

  localparam int ATTR_SRC_UP_BIT = 26;
  localparam int ATTR_DST_UP_BIT = 27;
  localparam int ATTR_IRQ_BIT = 31;
  localparam int IRQ_CHAN_BASE = 2;

  // Word offsets inside one channel window.
  localparam logic [4:0] CHN_OFF_SRC = 5'h00;
  localparam logic [4:0] CHN_OFF_DST = 5'h04;
  localparam logic [4:0] CHN_OFF_TAG = 5'h08;
  localparam logic [4:0] CHN_OFF_ATTR = 5'h0C;
  localparam logic [4:0] CHN_OFF_STAT = 5'h10;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_DONE  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [31:0]        read_data;
    logic               access_error;
    logic               irq_line;
    logic               start_valid;
    logic [CHAN_W-1:0]  start_channel;
    logic [31:0]        start_source;
    logic [31:0]        start_destination;
    logic [BEATS_W-1:0] start_beats;
    logic               source_upward;
    logic               destination_upward;
    logic [DELAY_W-1:0] completion_delay;
  } result_t;

endpackage

@@ src/dmarb_req_if.sv @@
// Request channel: bus reads, bus writes and transfer-done events.
interface dmarb_req_if;
  import dmarb_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [31:0]         address;
  logic [31:0]         write_data;
  logic [CHAN_W-1:0]   done_channel;

  modport source (output valid, opcode, address, write_data, done_channel, input ready);
  modport sink (input valid, opcode, address, write_data, done_channel, output ready);
endinterface

@@ src/dmarb_rsp_if.sv @@
// Response channel: read data, error flag, interrupt level and transfer descriptor.
interface dmarb_rsp_if;
  import dmarb_pkg::*;

  logic                valid;
  logic                ready;
  logic [31:0]         read_data;
  logic                access_error;
  logic                irq_line;
  logic                start_valid;
  logic [CHAN_W-1:0]   start_channel;
  logic [31:0]         start_source;
  logic [31:0]         start_destination;
  logic [BEATS_W-1:0]  start_beats;
  logic                source_upward;
  logic                destination_upward;
  logic [DELAY_W-1:0]  completion_delay;

  modport source (
    output valid, read_data, access_error, irq_line, start_valid, start_channel,
           start_source, start_destination, start_beats, source_upward,
           destination_upward, completion_delay,
    input  ready
  );
  modport sink (
    input  valid, read_data, access_error, irq_line, start_valid, start_channel,
           start_source, start_destination, start_beats, source_upward,
           destination_upward, completion_delay,
    output ready
  );
endinterface

@@ src/dmarb_ctrl.sv @@
// Handshake controller that tracks whether the result register is occupied.
module dmarb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output dmarb_pkg::ctrl_cmd_t cmd
);
  import dmarb_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // The result register may be refilled in the cycle its item is taken.
  always_comb begin
    unique case (state)
      ST_EMPTY: req_ready = 1'b1;
      ST_FULL:  req_ready = rsp_ready;
      default:  req_ready = 1'b0;
    endcase
    rsp_valid = (state == ST_FULL);
    accept    = req_valid && req_ready;
    cmd.load  = accept;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (accept) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (rsp_ready && !accept) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

endmodule

@@ src/dmarb_datapath.sv @@
// Register file, address decode, descriptor build and result register.
module dmarb_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  dmarb_pkg::ctrl_cmd_t         cmd,
  input  logic                         cfg_write_enable,
  input  logic [dmarb_pkg::IRQ_W-1:0]  cfg_write_data,
  input  logic [1:0]                   opcode,
  input  logic [31:0]                  address,
  input  logic [31:0]                  write_data,
  input  logic [dmarb_pkg::CHAN_W-1:0] done_channel,
  output dmarb_pkg::result_t           result
);
  import dmarb_pkg::*;

  logic [IRQ_W-1:0] irq_enable;
  logic [IRQ_W-1:0] irq_status;
  logic [31:0]      fb_words [FB_WORDS];
  logic [31:0]      csc_words [MATRIX_WORDS];
  logic [31:0]      ch_src [CHANNEL_COUNT];
  logic [31:0]      ch_dst [CHANNEL_COUNT];
  logic [31:0]      ch_tag [CHANNEL_COUNT];
  logic [31:0]      ch_attr [CHANNEL_COUNT];
  logic [31:0]      ch_stat [CHANNEL_COUNT];

  opcode_t              op;
  logic                 is_wr;
  logic [31:0]          csc_off;
  logic [31:0]          fb_off;
  logic [31:0]          chn_off;
  logic [MAT_IDX_W-1:0] csc_idx;
  logic [FB_IDX_W-1:0]  fb_idx;
  logic [CHAN_W-1:0]    chn;
  logic                 in_csc;
  logic                 in_chn;
  logic                 in_fb;
  logic                 chn_bad;
  logic                 csc_we;
  logic                 fb_we;
  logic                 src_we;
  logic                 dst_we;
  logic                 tag_we;
  logic                 attr_we;
  logic                 stat_we;
  logic                 done_hit;
  logic [31:0]          start_attr;
  logic [IRQ_W-1:0]     irq_next;
  logic [IRQ_W-1:0]     done_bit;
  result_t              res_next;

  assign op      = opcode_t'(opcode);
  assign is_wr   = (op == OP_WRITE);
  assign csc_off = address - ADDR_CSC_BASE;
  assign fb_off  = address - ADDR_FB_BASE;
  assign chn_off = (address & CHN_LANE_MASK) - ADDR_CHN_BASE;
  assign csc_idx = csc_off[MAT_IDX_W+1:2];
  assign fb_idx  = fb_off[FB_IDX_W+1:2];
  assign chn     = address[6:5];
  assign in_csc  = (address >= ADDR_CSC_BASE) && (address < ADDR_CSC_END);
  assign in_chn  = (address >= ADDR_CHN_BASE) && (address < ADDR_CHN_END);
  assign in_fb   = (address >= ADDR_FB_BASE) && (address <= ADDR_FB_LAST)
                   && (address[1:0] == 2'b00);
  assign chn_bad = (chn > CHAN_LAST) || (chn_off > CHN_OFF_LAST)
                   || (chn_off[1:0] != 2'b00);
  assign done_hit = (op == OP_DONE) && (done_channel <= CHAN_LAST);
  // The channel interrupt bits sit above the two low status bits.
  assign done_bit = IRQ_W'(1) << (3'(done_channel) + 3'(IRQ_CHAN_BASE));

  always_comb begin
    res_next   = '0;
    irq_next   = irq_status;
    csc_we     = 1'b0;
    fb_we      = 1'b0;
    src_we     = 1'b0;
    dst_we     = 1'b0;
    tag_we     = 1'b0;
    attr_we    = 1'b0;
    stat_we    = 1'b0;
    start_attr = '0;
    unique case (op)
      OP_READ, OP_WRITE: begin
        priority if (in_csc) begin
          if (is_wr) csc_we = 1'b1;
          else res_next.read_data = csc_words[csc_idx];
        end else if (in_chn) begin
          if (chn_bad) begin
            res_next.access_error = 1'b1;
          end else begin
            unique case (chn_off[4:0])
              CHN_OFF_SRC: begin
                if (is_wr) src_we = 1'b1;
                else res_next.read_data = ch_src[chn];
              end
              CHN_OFF_DST: begin
                if (is_wr) dst_we = 1'b1;
                else res_next.read_data = ch_dst[chn];
              end
              CHN_OFF_TAG: begin
                if (is_wr) tag_we = 1'b1;
                else res_next.read_data = ch_tag[chn];
              end
              CHN_OFF_ATTR: begin
                if (is_wr) attr_we = 1'b1;
                else res_next.read_data = ch_attr[chn];
              end
              CHN_OFF_STAT: begin
                if (!is_wr) begin
                  res_next.read_data = ch_stat[chn];
                end else begin
                  stat_we = 1'b1;
                  if (write_data[0]) begin
                    // Start bit: hand the channel setup to the beat mover.
                    start_attr                  = ch_attr[chn];
                    res_next.start_valid        = 1'b1;
                    res_next.start_channel      = chn;
                    res_next.start_source       = ch_src[chn];
                    res_next.start_destination  = ch_dst[chn];
                    res_next.start_beats        = start_attr[BEATS_W-1:0];
                    res_next.source_upward      = start_attr[ATTR_SRC_UP_BIT];
                    res_next.destination_upward = start_attr[ATTR_DST_UP_BIT];
                    res_next.completion_delay   = {start_attr[BEATS_W-1:0], 3'b000};
                  end
                end
              end
              default: res_next.access_error = 1'b1;
            endcase
          end
        end else if (in_fb) begin
          if (is_wr) fb_we = 1'b1;
          else res_next.read_data = fb_words[fb_idx];
        end else if ((address == ADDR_IRQ_STATUS) && !is_wr) begin
          res_next.read_data = 32'(irq_status);
        end else if ((address == ADDR_ERR_STATUS) && !is_wr) begin
          res_next.read_data = '0;
        end else if ((address == ADDR_IRQ_CLEAR) && is_wr) begin
          irq_next = irq_status & ~write_data[IRQ_W-1:0];
        end else begin
          res_next.access_error = 1'b1;
        end
      end
      OP_DONE: begin
        if (done_hit && ch_attr[done_channel][ATTR_IRQ_BIT]) begin
          irq_next = irq_status | done_bit;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
    res_next.irq_line = |(irq_next & irq_enable);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable <= '1;
      irq_status <= '0;
      for (int i = 0; i < FB_WORDS; i++) fb_words[i] <= '0;
      for (int i = 0; i < MATRIX_WORDS; i++) csc_words[i] <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        ch_src[i]  <= '0;
        ch_dst[i]  <= '0;
        ch_tag[i]  <= '0;
        ch_attr[i] <= '0;
        ch_stat[i] <= '0;
      end
    end else begin
      if (cfg_write_enable) irq_enable <= cfg_write_data;
      if (cmd.load) begin
        irq_status <= irq_next;
        if (csc_we) csc_words[csc_idx] <= write_data;
        if (fb_we) fb_words[fb_idx] <= write_data;
        if (src_we) ch_src[chn] <= write_data;
        if (dst_we) ch_dst[chn] <= write_data;
        if (tag_we) ch_tag[chn] <= write_data;
        if (attr_we) ch_attr[chn] <= write_data & ATTR_KEEP;
        if (stat_we) ch_stat[chn] <= write_data;
        if (done_hit) ch_stat[done_channel][0] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) result <= res_next;
  end

endmodule

@@ src/dma_register_block_with_irq_top.sv @@
// Top level of the DMA register block with interrupt status.
//
// Usage: the req channel carries one item per bus read, bus write or
// transfer-done event. Each accepted item yields exactly one item on the rsp
// channel with the read data, an access error flag, the interrupt level
// after the item and, for a status write with bit 0 set, a transfer
// descriptor for the external beat mover.
// The result is registered at the edge that accepts the item and is offered
// on rsp from the next cycle on. Throughput is one item per cycle while the
// receiver takes every result; the whole decode and register update of an
// item is done in the accept cycle by the datapath, and the controller only
// tracks whether the single result register is occupied.
// When the receiver stalls, the held result stays on rsp and req.ready
// drops; in the cycle the result is taken a new item can be accepted.
// irq_enable is written through cfg_write_enable and cfg_write_data; the user
// must do so only while the block is idle, as the block does not enforce it.
// Reset (rst, synchronous, active high) clears every register of the map,
// the interrupt status and the result register flag, and sets irq_enable
// to all ones. No clearing pass is needed: the block is ready right away.
module dma_register_block_with_irq_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [dmarb_pkg::IRQ_W-1:0] cfg_write_data,
  dmarb_req_if.sink                   req,
  dmarb_rsp_if.source                 rsp
);
  import dmarb_pkg::*;

  ctrl_cmd_t cmd;
  result_t   result;

  dmarb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  dmarb_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .opcode           (req.opcode),
    .address          (req.address),
    .write_data       (req.write_data),
    .done_channel     (req.done_channel),
    .result           (result)
  );

  // The result register fields go out on the response channel unchanged.
  assign rsp.read_data          = result.read_data;
  assign rsp.access_error       = result.access_error;
  assign rsp.irq_line           = result.irq_line;
  assign rsp.start_valid        = result.start_valid;
  assign rsp.start_channel      = result.start_channel;
  assign rsp.start_source       = result.start_source;
  assign rsp.start_destination  = result.start_destination;
  assign rsp.start_beats        = result.start_beats;
  assign rsp.source_upward      = result.source_upward;
  assign rsp.destination_upward = result.destination_upward;
  assign rsp.completion_delay   = result.completion_delay;

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> rsp.valid)
    else $error("accepted item produced no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("new item accepted while result is stalled");

  a_delay_matches_beats: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.start_valid |-> rsp.completion_delay == {rsp.start_beats, 3'b000})
    else $error("completion delay does not match beat count");

  a_error_is_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.access_error |-> rsp.read_data == 32'd0 && !rsp.start_valid)
    else $error("errored access returned data or started a transfer");
`endif

endmodule

@@ dv/dmarb_register_checker.sv @@
// Checker for the DMA register block: keeps a shadow of the map and compares every result.
module dmarb_register_checker
  import dmarb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_enable,
  input  logic [IRQ_W-1:0] cfg_write_data,
  dmarb_req_if             req,
  dmarb_rsp_if             rsp,
  output int               error_count,
  output int               outstanding
);

  // Shadow copy of the configuration and of every register in the map.
  logic [IRQ_W-1:0] shadow_irq_enable;
  logic [IRQ_W-1:0] shadow_irq_status;
  logic [31:0]      shadow_fb_words [FB_WORDS];
  logic [31:0]      shadow_color_words [MATRIX_WORDS];
  logic [31:0]      shadow_chan_source [CHANNEL_COUNT];
  logic [31:0]      shadow_chan_destination [CHANNEL_COUNT];
  logic [31:0]      shadow_chan_tag [CHANNEL_COUNT];
  logic [31:0]      shadow_chan_attributes [CHANNEL_COUNT];
  logic [31:0]      shadow_chan_status [CHANNEL_COUNT];

  result_t expected_results [$];
  int      mismatches = 0;
  int      pending = 0;
  int      results_seen = 0;

  assign error_count = mismatches;
  assign outstanding = pending;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  task automatic clear_shadow();
    shadow_irq_enable = '1;
    shadow_irq_status = '0;
    foreach (shadow_fb_words[i]) shadow_fb_words[i] = '0;
    foreach (shadow_color_words[i]) shadow_color_words[i] = '0;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      shadow_chan_source[c] = '0;
      shadow_chan_destination[c] = '0;
      shadow_chan_tag[c] = '0;
      shadow_chan_attributes[c] = '0;
      shadow_chan_status[c] = '0;
    end
  endtask

  // Applies one bus access or done event to the shadow map and returns the
  // result the block must give for it.
  function automatic result_t predict_register_access(input opcode_t op,
                                                      input logic [31:0] addr,
                                                      input logic [31:0] wdata,
                                                      input logic [CHAN_W-1:0] chan);
    result_t     r;
    logic        is_write;
    logic [31:0] lane_off;
    logic [31:0] attr;
    int          idx;
    int          c;
    r = '0;
    is_write = (op == OP_WRITE);
    if (op == OP_READ || op == OP_WRITE) begin
      if (addr >= ADDR_CSC_BASE && addr < ADDR_CSC_END) begin
        idx = int'((addr - ADDR_CSC_BASE) >> 2);
        if (is_write) shadow_color_words[idx] = wdata;
        else r.read_data = shadow_color_words[idx];
      end else if (addr >= ADDR_CHN_BASE && addr < ADDR_CHN_END) begin
        c = int'(addr[6:5]);
        lane_off = (addr & CHN_LANE_MASK) - ADDR_CHN_BASE;
        if (c >= CHANNEL_COUNT || lane_off > CHN_OFF_LAST || lane_off[1:0] != 2'b00) begin
          r.access_error = 1'b1;
        end else begin
          case (lane_off[4:0])
            CHN_OFF_SRC: begin
              if (is_write) shadow_chan_source[c] = wdata;
              else r.read_data = shadow_chan_source[c];
            end
            CHN_OFF_DST: begin
              if (is_write) shadow_chan_destination[c] = wdata;
              else r.read_data = shadow_chan_destination[c];
            end
            CHN_OFF_TAG: begin
              if (is_write) shadow_chan_tag[c] = wdata;
              else r.read_data = shadow_chan_tag[c];
            end
            CHN_OFF_ATTR: begin
              if (is_write) shadow_chan_attributes[c] = wdata & ATTR_KEEP;
              else r.read_data = shadow_chan_attributes[c];
            end
            default: begin
              if (!is_write) begin
                r.read_data = shadow_chan_status[c];
              end else begin
                shadow_chan_status[c] = wdata;
                // Bit 0 of a status write kicks off a transfer descriptor.
                if (wdata[0]) begin
                  attr = shadow_chan_attributes[c];
                  r.start_valid = 1'b1;
                  r.start_channel = CHAN_W'(c);
                  r.start_source = shadow_chan_source[c];
                  r.start_destination = shadow_chan_destination[c];
                  r.start_beats = attr[BEATS_W-1:0];
                  r.source_upward = attr[ATTR_SRC_UP_BIT];
                  r.destination_upward = attr[ATTR_DST_UP_BIT];
                  r.completion_delay = {attr[BEATS_W-1:0], 3'b000};
                end
              end
            end
          endcase
        end
      end else if (addr >= ADDR_FB_BASE && addr <= ADDR_FB_LAST && addr[1:0] == 2'b00) begin
        idx = int'((addr - ADDR_FB_BASE) >> 2);
        if (is_write) shadow_fb_words[idx] = wdata;
        else r.read_data = shadow_fb_words[idx];
      end else if (addr == ADDR_IRQ_STATUS && !is_write) begin
        r.read_data = 32'(shadow_irq_status);
      end else if (addr == ADDR_ERR_STATUS && !is_write) begin
        r.read_data = '0;
      end else if (addr == ADDR_IRQ_CLEAR && is_write) begin
        shadow_irq_status = shadow_irq_status & ~wdata[IRQ_W-1:0];
      end else begin
        r.access_error = 1'b1;
      end
    end else if (op == OP_DONE) begin
      if (chan < CHANNEL_COUNT) begin
        shadow_chan_status[chan][0] = 1'b0;
        if (shadow_chan_attributes[chan][ATTR_IRQ_BIT])
          shadow_irq_status[int'(chan) + IRQ_CHAN_BASE] = 1'b1;
      end
    end
    r.irq_line = |(shadow_irq_status & shadow_irq_enable);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      clear_shadow();
      expected_results.delete();
    end else begin
      if (cfg_write_enable) shadow_irq_enable = cfg_write_data;
      // A result is registered when its item is accepted and leaves later, so the
      // result taken at this edge always belongs to an item already queued.
      if (rsp.valid && rsp.ready) begin
        got.read_data = rsp.read_data;
        got.access_error = rsp.access_error;
        got.irq_line = rsp.irq_line;
        got.start_valid = rsp.start_valid;
        got.start_channel = rsp.start_channel;
        got.start_source = rsp.start_source;
        got.start_destination = rsp.start_destination;
        got.start_beats = rsp.start_beats;
        got.source_upward = rsp.source_upward;
        got.destination_upward = rsp.destination_upward;
        got.completion_delay = rsp.completion_delay;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item waiting for it",
                                    results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", got.read_data, want.read_data);
          check_field("access_error", 32'(got.access_error), 32'(want.access_error));
          check_field("irq_line", 32'(got.irq_line), 32'(want.irq_line));
          check_field("start_valid", 32'(got.start_valid), 32'(want.start_valid));
          check_field("start_channel", 32'(got.start_channel), 32'(want.start_channel));
          check_field("start_source", got.start_source, want.start_source);
          check_field("start_destination", got.start_destination, want.start_destination);
          check_field("start_beats", 32'(got.start_beats), 32'(want.start_beats));
          check_field("source_upward", 32'(got.source_upward), 32'(want.source_upward));
          check_field("destination_upward", 32'(got.destination_upward),
                      32'(want.destination_upward));
          check_field("completion_delay", 32'(got.completion_delay),
                      32'(want.completion_delay));
        end
        results_seen++;
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(predict_register_access(opcode_t'(req.opcode), req.address,
                                                           req.write_data, req.done_channel));
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ dv/tb_dma_register_block_with_irq_top.sv @@
// Top of the DMA register block testbench: clock, reset, stimulus and verdict.
module tb_dma_register_block_with_irq_top;
  import dmarb_pkg::*;

  // A stretch this long without a single item moving on either channel means
  // the block has hung. The longest legitimate quiet spell is the deliberate
  // receiver hold-off below, which is far shorter.
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int ITEMS_PER_PHASE = 135;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_enable;
  logic [IRQ_W-1:0] cfg_write_data;

  dmarb_req_if req_ch();
  dmarb_rsp_if rsp_ch();

  int mismatch_total;
  int results_pending;

  // Idle rates in percent for each side; the stimulus changes them per phase.
  int send_idle_pct = 27;
  int recv_idle_pct = 84;
  // Set by the stimulus to make the receiver refuse results for a while.
  int rsp_hold_cycles = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  dma_register_block_with_irq_top dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .req              (req_ch),
    .rsp              (rsp_ch)
  );

  dmarb_register_checker checker_inst (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .req              (req_ch),
    .rsp              (rsp_ch),
    .error_count      (mismatch_total),
    .outstanding      (results_pending)
  );

  always #5 clk = ~clk;

  // Receiver. Ready changes only at the falling edge. A pending hold-off is
  // counted down here, once per falling edge, while the sender keeps on
  // offering items; with a single result register the block soon drops its
  // input ready and the sender has to wait.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offers one item and returns at the falling edge after it was accepted.
  // Valid stays high afterwards so that back-to-back items need no gap; the
  // idle loop of the next call lowers it when the sender decides to idle.
  task automatic send_item(input opcode_t op, input logic [31:0] addr,
                           input logic [31:0] data, input logic [CHAN_W-1:0] chan);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.opcode = op;
    req_ch.address = addr;
    req_ch.write_data = data;
    req_ch.done_channel = chan;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // The sender stops and waits until every result it is owed has come back.
  // Every item yields a result, so an empty queue means the block is idle.
  task automatic wait_for_drain();
    req_ch.valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // The interrupt mask may only change while the block is idle.
  task automatic set_irq_enable(input logic [IRQ_W-1:0] mask);
    wait_for_drain();
    cfg_write_enable = 1'b1;
    cfg_write_data = mask;
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  // Addresses are drawn mostly from the mapped regions and their edges, with
  // misaligned offsets, the gaps between channel words, the word past the end
  // of each region, and fully random addresses so that every bit toggles.
  function automatic logic [31:0] random_address();
    case ($urandom_range(9))
      0: return $urandom();
      1: return {ADDR_IRQ_STATUS[31:4], 4'($urandom_range(15))};
      2: return ADDR_FB_BASE + 32'($urandom_range(19));
      3, 4: return ADDR_CSC_BASE + 32'($urandom_range(4 * MATRIX_WORDS));
      8: return ADDR_CHN_BASE + 32'($urandom_range(95));
      9: return {ADDR_IRQ_STATUS[31:9], 9'($urandom_range(511))};
      default: return ADDR_CHN_BASE + 32'(32 * $urandom_range(CHANNEL_COUNT - 1))
                      + 32'(4 * $urandom_range(4));
    endcase
  endfunction

  // One loose item: any opcode including the no-op code, any address, and a
  // done channel that is sometimes beyond the last channel.
  task automatic send_random_item();
    int pick;
    opcode_t op;
    logic [31:0] data;
    pick = $urandom_range(19);
    if (pick < 8) op = OP_READ;
    else if (pick < 16) op = OP_WRITE;
    else if (pick < 19) op = OP_DONE;
    else op = OP_NOP;
    case ($urandom_range(7))
      0: data = '0;
      1: data = '1;
      default: data = $urandom();
    endcase
    send_item(op, random_address(), data, CHAN_W'($urandom_range(3)));
  endtask

  // A well-formed transfer on one channel: program source, destination and
  // attributes, start it through the status word, let the mover report done,
  // then look at the status and interrupt words and maybe clear interrupts.
  task automatic run_transfer();
    logic [CHAN_W-1:0] ch;
    logic [31:0] window;
    logic [31:0] attr;
    ch = CHAN_W'($urandom_range(CHANNEL_COUNT - 1));
    window = ADDR_CHN_BASE + 32'(ch) * 32'd32;
    attr = $urandom();
    if ($urandom_range(3) != 0) attr[BEATS_W-1:0] = BEATS_W'($urandom_range(64));
    send_item(OP_WRITE, window + 32'(CHN_OFF_SRC), $urandom(), CHAN_W'($urandom_range(3)));
    send_item(OP_WRITE, window + 32'(CHN_OFF_DST), $urandom(), CHAN_W'($urandom_range(3)));
    if ($urandom_range(2) == 0)
      send_item(OP_WRITE, window + 32'(CHN_OFF_TAG), $urandom(), CHAN_W'($urandom_range(3)));
    send_item(OP_WRITE, window + 32'(CHN_OFF_ATTR), attr, CHAN_W'($urandom_range(3)));
    send_item(OP_WRITE, window + 32'(CHN_OFF_STAT), $urandom() | 32'h1,
              CHAN_W'($urandom_range(3)));
    if ($urandom_range(1) == 0)
      send_item(OP_READ, window + 32'(4 * $urandom_range(4)), $urandom(),
                CHAN_W'($urandom_range(3)));
    send_item(OP_DONE, $urandom(), $urandom(), ch);
    send_item(OP_READ, window + 32'(CHN_OFF_STAT), $urandom(), CHAN_W'($urandom_range(3)));
    send_item(OP_READ, ADDR_IRQ_STATUS, $urandom(), CHAN_W'($urandom_range(3)));
    if ($urandom_range(1) == 0)
      send_item(OP_WRITE, ADDR_IRQ_CLEAR, $urandom(), CHAN_W'($urandom_range(3)));
  endtask

  // Mostly well-formed transfers with random content, the rest loose items.
  // Now and then the sender pauses until the block has drained.
  task automatic run_phase(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 55) run_transfer();
      else send_random_item();
      if ($urandom_range(49) == 0) wait_for_drain();
    end
  endtask

  initial begin
    logic [31:0] last_window;
    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_READ;
    req_ch.address = '0;
    req_ch.write_data = '0;
    req_ch.done_channel = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the interrupt mask at its reset value of all ones.
    // Interrupt, clear and error words, including the wrong-direction cases.
    send_item(OP_READ, ADDR_IRQ_STATUS, '0, '0);
    send_item(OP_READ, ADDR_ERR_STATUS, '1, 2'd3);
    send_item(OP_READ, ADDR_IRQ_CLEAR, '0, '0);
    send_item(OP_WRITE, ADDR_IRQ_STATUS, '1, '0);
    send_item(OP_WRITE, ADDR_ERR_STATUS, '1, '0);
    // Address extremes land outside the map.
    send_item(OP_WRITE, 32'h0, '1, '0);
    send_item(OP_READ, '1, '0, '0);
    // Last framebuffer word and a misaligned framebuffer address.
    send_item(OP_WRITE, ADDR_FB_LAST, '1, '0);
    send_item(OP_READ, ADDR_FB_LAST, '0, '0);
    send_item(OP_READ, ADDR_FB_BASE + 32'h2, '0, '0);
    // Any byte of a color word selects it; the byte past the end does not.
    send_item(OP_WRITE, ADDR_CSC_END - 32'h1, '1, '0);
    send_item(OP_READ, ADDR_CSC_END - 32'h4, '0, '0);
    send_item(OP_READ, ADDR_CSC_END, '0, '0);
    // Last channel with every attribute bit set: the unkept bits read back as
    // zero, and the start carries the largest beat count and delay.
    last_window = ADDR_CHN_BASE + 32'(CHAN_LAST) * 32'd32;
    send_item(OP_WRITE, last_window + 32'(CHN_OFF_SRC), '1, '0);
    send_item(OP_WRITE, last_window + 32'(CHN_OFF_ATTR), '1, '0);
    send_item(OP_READ, last_window + 32'(CHN_OFF_ATTR), '0, '0);
    send_item(OP_WRITE, last_window + 32'(CHN_OFF_STAT), 32'h1, '0);
    // Misaligned channel address, the gap after a channel's status word, and
    // the first address past the channel window.
    send_item(OP_WRITE, last_window + 32'h2, '1, '0);
    send_item(OP_READ, ADDR_CHN_BASE + 32'h14, '0, '0);
    send_item(OP_READ, ADDR_CHN_END, '0, '0);
    // Done on the busy last channel raises its interrupt; a done beyond the
    // last channel is ignored, and one on an idle channel is handled as usual.
    send_item(OP_DONE, '0, '0, CHAN_LAST);
    send_item(OP_DONE, '1, '1, 2'd3);
    send_item(OP_DONE, '0, '0, '0);
    send_item(OP_NOP, '1, '1, 2'd3);
    // A start with all attributes zero gives an all-zero descriptor.
    send_item(OP_WRITE, ADDR_CHN_BASE + 32'(CHN_OFF_STAT), 32'h1, '0);
    send_item(OP_WRITE, ADDR_IRQ_CLEAR, '1, '0);

    // Phase one: sender idles a little, receiver a lot, interrupts masked off.
    set_irq_enable('0);
    run_phase(ITEMS_PER_PHASE);

    // Phase two: the other way round, with a partial mask.
    set_irq_enable(IRQ_W'($urandom_range(1, 30)));
    send_idle_pct = 84;
    recv_idle_pct = 27;
    run_phase(ITEMS_PER_PHASE);

    // Phase three: nobody idles, all interrupts enabled again. It opens with
    // a long receiver hold-off while the sender keeps pushing items.
    set_irq_enable('1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rsp_hold_cycles = HOLD_OFF_CYCLES;
    run_phase(ITEMS_PER_PHASE);

    // Drain, then keep watching so that any stray result would show before the verdict.
    wait_for_drain();
    repeat (4) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dmarb_pkg.sv
src/dmarb_req_if.sv
src/dmarb_rsp_if.sv
src/dmarb_ctrl.sv
src/dmarb_datapath.sv
src/dma_register_block_with_irq_top.sv
dv/dmarb_register_checker.sv
dv/tb_dma_register_block_with_irq_top.sv
